>>> hw/rtl/oiq_pkg.sv
// Shared widths, request codes and status codes for the ordered insert queue.
package oiq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int VAL_W = 32;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;
    localparam int OCC_W = 5;

    localparam logic [REQ_W-1:0] REQ_APPEND  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ORDERED = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

>>> hw/rtl/oiq_if.sv
// Request and response channel interfaces for the ordered insert queue.
interface oiq_req_if;
    logic                                valid;
    logic                                ready;
    logic [oiq_pkg::REQ_W-1:0]           req_type;
    logic signed [oiq_pkg::VAL_W-1:0]    in_value;

    modport source (output valid, output req_type, output in_value, input ready);
    modport sink   (input valid, input req_type, input in_value, output ready);
endinterface

interface oiq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [oiq_pkg::VAL_W-1:0]    out_value;
    logic [oiq_pkg::ST_W-1:0]            status;
    logic [oiq_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output out_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input out_value, input status, input occupancy,
                    output ready);
endinterface

>>> hw/rtl/ordered_insert_queue.sv
// Ordered insert queue: bounded queue of signed values with append, ordered insert, remove.
// Entries live in a single-port-write, single-port-read memory with the head at
// address 0, and one compare unit under a small sequencer does all the work. The
// block takes one request at a time; an append writes at the tail, an ordered
// insert scans up to its position p, then moves the tail up one entry per cycle,
// and a remove reads the head, then moves every entry down one per cycle. The
// memory's one read and one write per cycle set this pace. Full, empty and unused
// requests go straight to the finish state. The result sits in an output
// register, so the next request is taken while a finished result waits.
module ordered_insert_queue #(
    parameter int CAPACITY = oiq_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    oiq_req_if.sink        req,
    oiq_rsp_if.source      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_PUT,
        S_RM_HEAD,
        S_SHIFT_DN,
        S_FIN
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic signed [oiq_pkg::VAL_W-1:0]  val_reg, val_next;
    logic [AW-1:0]                     pos_reg, pos_next;
    logic [AW-1:0]                     idx_reg, idx_next;
    logic signed [oiq_pkg::VAL_W-1:0]  res_value_reg, res_value_next;
    logic [oiq_pkg::ST_W-1:0]          res_status_reg, res_status_next;

    logic                              out_valid_reg, out_valid_next;
    logic signed [oiq_pkg::VAL_W-1:0]  out_value_reg, out_value_next;
    logic [oiq_pkg::ST_W-1:0]          out_status_reg, out_status_next;
    logic [oiq_pkg::OCC_W-1:0]         out_occ_reg, out_occ_next;

    logic signed [oiq_pkg::VAL_W-1:0]  mem [CAPACITY];
    logic signed [oiq_pkg::VAL_W-1:0]  rdata;
    logic [AW-1:0]                     mem_raddr;
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [oiq_pkg::VAL_W-1:0]  mem_wdata;

    logic                              req_fire;
    logic                              found;
    logic                              is_full;

    assign req.ready     = (state_reg == S_IDLE);
    assign req_fire      = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.occupancy = out_occ_reg;

    assign is_full = (count_reg == CW'(CAPACITY));
    // the head is passed only by a strictly smaller value; later entries by a not-greater one
    assign found = (idx_reg == '0) ? (rdata > val_reg) : (rdata >= val_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    val_next        = req.in_value;
                    res_value_next  = '0;
                    res_status_next = oiq_pkg::ST_OK;
                    idx_next        = '0;
                    case (req.req_type)
                        oiq_pkg::REQ_APPEND,
                        oiq_pkg::REQ_ORDERED:
                        begin
                            if (is_full)
                            begin
                                res_status_next = oiq_pkg::ST_FULL;
                                state_next      = S_FIN;
                            end
                            else if (req.req_type == oiq_pkg::REQ_APPEND || count_reg == '0)
                            begin
                                pos_next   = AW'(count_reg);
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        oiq_pkg::REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = oiq_pkg::ST_EMPTY;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                state_next = S_RM_HEAD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (found)
                begin
                    // open a gap at idx: move entries count-1 .. idx up by one
                    pos_next   = idx_reg;
                    mem_raddr  = AW'(count_reg - CW'(1));
                    idx_next   = AW'(count_reg - CW'(1));
                    state_next = S_SHIFT_UP;
                end
                else if ((CW'(idx_reg) + CW'(1)) == count_reg)
                begin
                    pos_next   = AW'(count_reg);
                    state_next = S_PUT;
                end
                else
                begin
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end

            S_SHIFT_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + AW'(1);
                mem_wdata = rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_raddr = idx_reg - AW'(1);
                    idx_next  = idx_reg - AW'(1);
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_FIN;
            end

            S_RM_HEAD:
            begin
                res_value_next = rdata;
                count_next     = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    mem_raddr  = AW'(1);
                    idx_next   = AW'(1);
                    state_next = S_SHIFT_DN;
                end
            end

            S_SHIFT_DN:
            begin
                // count already holds the new size, so idx == count marks the last entry
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = rdata;
                if (CW'(idx_reg) == count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_occ_next    = oiq_pkg::OCC_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
    end

endmodule

>>> test/ordered_insert_queue_tb.sv
// Testbench for ordered_insert_queue: random and directed requests checked against a shadow queue.
module ordered_insert_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP       = oiq_pkg::CAPACITY_DEF;
    localparam int N_RANDOM  = 800;
    localparam int HOLD_AT   = 40;
    localparam int HOLD_LEN  = 400;
    localparam int DRAIN_CYC = 60;

    localparam logic [oiq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [oiq_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [oiq_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [oiq_pkg::REQ_W-1:0]        kind;
        logic signed [oiq_pkg::VAL_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic signed [oiq_pkg::VAL_W-1:0] value;
        logic [oiq_pkg::ST_W-1:0]         status;
        logic [oiq_pkg::OCC_W-1:0]        occupancy;
    } response_t;

    logic clk;
    logic rst_n;

    oiq_req_if req_ch ();
    oiq_rsp_if rsp_ch ();

    ordered_insert_queue #(.CAPACITY(CAP)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    request_t                         pending_items[$];
    response_t                        expected_results[$];
    logic signed [oiq_pkg::VAL_W-1:0] held_values[$];

    int error_count = 0;
    int accepted_n  = 0;
    int phase_cut1  = 0;
    int phase_cut2  = 0;
    int hold_left   = 0;
    bit hold_done   = 0;

    int send_idle_pct[3] = '{31, 65, 0};
    int recv_idle_pct[3] = '{65, 31, 0};

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int idle_phase(input int n);
        if (n < phase_cut1)
            return 0;
        else if (n < phase_cut2)
            return 1;
        return 2;
    endfunction

    // Apply one accepted request to the shadow queue and record the result it should give.
    function automatic void advance_shadow_queue(input request_t it);
        response_t r;
        int        pos;
        r.value  = '0;
        r.status = oiq_pkg::ST_OK;
        case (it.kind)
            oiq_pkg::REQ_APPEND, oiq_pkg::REQ_ORDERED: begin
                if (held_values.size() >= CAP) begin
                    r.status = oiq_pkg::ST_FULL;
                end else if (it.kind == oiq_pkg::REQ_APPEND) begin
                    held_values.push_back(it.value);
                end else begin
                    // the head is only displaced by a strictly smaller value
                    if (held_values.size() == 0 || held_values[0] > it.value) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < held_values.size() && held_values[pos] < it.value)
                            pos++;
                    end
                    held_values.insert(pos, it.value);
                end
            end
            oiq_pkg::REQ_REMOVE: begin
                if (held_values.size() == 0)
                    r.status = oiq_pkg::ST_EMPTY;
                else
                    r.value = held_values.pop_front();
            end
            default: ;
        endcase
        r.occupancy = oiq_pkg::OCC_W'(held_values.size());
        expected_results.push_back(r);
    endfunction

    function automatic logic signed [oiq_pkg::VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return oiq_pkg::VAL_W'($signed($urandom_range(0, 16)) - 8);
        else if (sel < 50) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic add_item(input logic [oiq_pkg::REQ_W-1:0] kind,
                            input logic signed [oiq_pkg::VAL_W-1:0] v);
        request_t it;
        it.kind  = kind;
        it.value = v;
        pending_items.push_back(it);
    endtask

    always #5 clk = ~clk;

    // request driver
    always @(posedge clk or negedge rst_n) begin
        request_t it;
        bit       idle;
        if (!rst_n) begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= '0;
            req_ch.in_value <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
                it.kind  = req_ch.req_type;
                it.value = req_ch.in_value;
                advance_shadow_queue(it);
                accepted_n++;
            end
            idle = (hold_left == 0) &&
                   ($urandom_range(0, 99) < send_idle_pct[idle_phase(accepted_n)]);
            if (pending_items.size() != 0 && !idle) begin
                it = pending_items.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= it.kind;
                req_ch.in_value <= it.value;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // one long receiver stall while the sender keeps offering items
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_n >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n) begin
        response_t exp_r;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= (hold_left == 0) &&
                            ($urandom_range(0, 99) >= recv_idle_pct[idle_phase(accepted_n)]);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report("result with no request outstanding");
                end else begin
                    exp_r = expected_results.pop_front();
                    if (rsp_ch.out_value !== exp_r.value)
                        report($sformatf("out_value %0d, expected %0d",
                                         rsp_ch.out_value, exp_r.value));
                    if (rsp_ch.status !== exp_r.status)
                        report($sformatf("status %0d, expected %0d",
                                         rsp_ch.status, exp_r.status));
                    if (rsp_ch.occupancy !== exp_r.occupancy)
                        report($sformatf("occupancy %0d, expected %0d",
                                         rsp_ch.occupancy, exp_r.occupancy));
                end
            end
        end
    end

    initial begin
        int                          counted;
        int                          burst_len;
        int                          mode;
        int                          sel;
        int                          insert_pct;
        logic [oiq_pkg::REQ_W-1:0]   kind;

        clk   = 1'b0;
        rst_n = 1'b0;

        // directed: empty and unused codes, extremes, equal keys, fill to full, overflow
        add_item(oiq_pkg::REQ_REMOVE, VAL_MAX);
        add_item(REQ_UNUSED, VAL_MIN);
        add_item(oiq_pkg::REQ_APPEND, VAL_MAX);
        add_item(oiq_pkg::REQ_ORDERED, VAL_MIN);
        add_item(oiq_pkg::REQ_ORDERED, VAL_MIN);
        add_item(oiq_pkg::REQ_ORDERED, 32'sd0);
        add_item(oiq_pkg::REQ_ORDERED, -32'sd1);
        add_item(oiq_pkg::REQ_ORDERED, 32'sd0);
        add_item(oiq_pkg::REQ_ORDERED, VAL_MAX);
        add_item(oiq_pkg::REQ_ORDERED, 32'sd7);
        add_item(oiq_pkg::REQ_APPEND, -32'sd1);
        add_item(oiq_pkg::REQ_ORDERED, 32'sd3);
        add_item(oiq_pkg::REQ_ORDERED, 32'sd100);
        add_item(oiq_pkg::REQ_APPEND, 32'sd0);
        add_item(oiq_pkg::REQ_ORDERED, 32'sd2);
        add_item(oiq_pkg::REQ_ORDERED, 32'sd2);
        add_item(oiq_pkg::REQ_ORDERED, -32'sd50);
        add_item(oiq_pkg::REQ_APPEND, 32'sh5555_aaaa);
        add_item(oiq_pkg::REQ_APPEND, 32'sh1234_5678);
        add_item(oiq_pkg::REQ_ORDERED, VAL_MIN);
        add_item(oiq_pkg::REQ_REMOVE, 32'sd0);
        add_item(oiq_pkg::REQ_REMOVE, -32'sd1);
        add_item(REQ_UNUSED, 32'sd0);
        add_item(oiq_pkg::REQ_REMOVE, 32'sd0);

        // random bursts: filling, draining, mixed and ordered-only runs
        counted = 0;
        while (counted < N_RANDOM) begin
            burst_len = $urandom_range(5, 40);
            mode      = $urandom_range(0, 3);
            case (mode)
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 55;
            endcase
            repeat (burst_len) begin
                sel = $urandom_range(0, 99);
                if (sel < 2)
                    kind = REQ_UNUSED;
                else if ($urandom_range(0, 99) < insert_pct)
                    kind = (mode == 3 || $urandom_range(0, 1)) ? oiq_pkg::REQ_ORDERED
                                                                : oiq_pkg::REQ_APPEND;
                else
                    kind = oiq_pkg::REQ_REMOVE;
                add_item(kind, pick_value());
                if (kind != REQ_UNUSED)
                    counted++;
            end
        end

        phase_cut1 = pending_items.size() / 3;
        phase_cut2 = 2 * pending_items.size() / 3;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (expected_results.size() != 0)
            report("results still outstanding at end of run");

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
